FILE: src/pbd_pkg.sv
// Shared types and constants of the PackBits run-length decoder.
package pbd_pkg;

	// Tokens at or above this value announce a repeat.
	localparam logic [7:0] REPEAT_TOKEN_MIN = 8'd128;
	// Repeat count is this base minus the token.
	localparam logic [8:0] REPEAT_BASE = 9'd257;
	// Number of byte fields in one result.
	localparam int LANE_MAX = 4;

	// One compressed byte from the input channel.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	// One decoded result.
	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [2:0] byte_count;
		logic       last_of_run;
		logic       status;
	} out_item_t;

	// Command passed from the front end to the back end.
	// A count of zero means a status-only result.
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] count;
		logic       status;
	} cmd_t;

endpackage

FILE: src/pbd_in_if.sv
// Input channel carrying one compressed byte per transaction.
interface pbd_in_if;
	logic              valid;
	logic              ready;
	pbd_pkg::in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/pbd_out_if.sv
// Output channel carrying one decoded result per transaction.
interface pbd_out_if;
	logic               valid;
	logic               ready;
	pbd_pkg::out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/pbd_front.sv
// Front end: accepts compressed bytes, tracks the token phase and issues commands.
module pbd_front (
	input  logic         clk,
	input  logic         arst_n,
	pbd_in_if.sink       item,
	input  logic         q_full,
	output logic         push,
	output pbd_pkg::cmd_t push_cmd
);

	typedef enum logic [2:0] {
		PH_TOKEN = 3'b001,
		PH_FILL  = 3'b010,
		PH_LIT   = 3'b100
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] remaining_q, remaining_n;
	logic [7:0] repeat_q, repeat_n;
	logic       accept;
	logic [7:0] b;
	logic       last_in;
	logic [7:0] rem_dec;
	logic [8:0] rep_calc;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign b          = item.data.in_byte;
	assign last_in    = item.data.end_of_input;
	assign rem_dec    = remaining_q - 8'd1;
	assign rep_calc   = pbd_pkg::REPEAT_BASE - {1'b0, b};

	// Classify the accepted byte according to the current phase.
	always_comb begin
		phase_n     = phase_q;
		remaining_n = remaining_q;
		repeat_n    = repeat_q;
		push        = 1'b0;
		push_cmd    = '{data: b, count: 8'd0, status: 1'b0};
		if (accept) begin
			unique case (phase_q)
				PH_FILL: begin
					push           = 1'b1;
					push_cmd.count = repeat_q;
					phase_n        = PH_TOKEN;
				end
				PH_LIT: begin
					push           = 1'b1;
					push_cmd.count = 8'd1;
					push_cmd.status = (rem_dec != 8'd0) && last_in;
					remaining_n    = rem_dec;
					if (rem_dec == 8'd0 || last_in) begin
						phase_n = PH_TOKEN;
					end
				end
				default: begin
					if (b >= pbd_pkg::REPEAT_TOKEN_MIN) begin
						repeat_n = rep_calc[7:0];
						phase_n  = PH_FILL;
					end else begin
						remaining_n = b + 8'd1;
						phase_n     = PH_LIT;
					end
					// A final token leaves the stream truncated.
					if (last_in) begin
						push            = 1'b1;
						push_cmd.status = 1'b1;
						phase_n         = PH_TOKEN;
					end
				end
			endcase
		end
	end

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
		end else begin
			phase_q <= phase_n;
		end
	end

	// Token counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= 8'd0;
			repeat_q    <= 8'd0;
		end else begin
			remaining_q <= remaining_n;
			repeat_q    <= repeat_n;
		end
	end

endmodule

FILE: src/pbd_queue.sv
// Two-entry command queue between the front end and the back end.
module pbd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pbd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output pbd_pkg::cmd_t head
);

	pbd_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/pbd_back.sv
// Back end: expands queued commands into results of up to LANES bytes each.
module pbd_back #(
	parameter int LANES = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  pbd_pkg::cmd_t head,
	output logic          pop,
	pbd_out_if.source     result
);

	localparam logic [7:0] LANE_CNT = 8'(LANES);

	logic       started_q;
	logic [7:0] left_q;
	logic [7:0] left;
	logic [7:0] chunk;
	logic [2:0] chunk_n;
	logic [7:0] rest;
	logic       last;
	logic       emit;
	logic       out_valid_q;
	pbd_pkg::out_item_t out_q;

	// Size of the next result taken from the head command.
	assign left    = started_q ? left_q : head.count;
	assign chunk   = (left < LANE_CNT) ? left : LANE_CNT;
	assign chunk_n = chunk[2:0];
	assign rest    = left - chunk;
	assign last    = (rest == 8'd0);
	assign emit    = head_valid && (!out_valid_q || result.ready);
	assign pop     = emit && last;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Progress through the head command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				started_q <= !last;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; unused lanes read as zero.
	always_ff @(posedge clk) begin
		if (emit) begin
			left_q               <= rest;
			out_q.out_byte0      <= (chunk_n > 3'd0) ? head.data : 8'd0;
			out_q.out_byte1      <= (chunk_n > 3'd1) ? head.data : 8'd0;
			out_q.out_byte2      <= (chunk_n > 3'd2) ? head.data : 8'd0;
			out_q.out_byte3      <= (chunk_n > 3'd3) ? head.data : 8'd0;
			out_q.byte_count     <= chunk_n;
			out_q.last_of_run    <= last;
			out_q.status         <= head.status;
		end
	end

endmodule

FILE: src/packbits_rle_decoder.sv
// Top level of the PackBits run-length decoder.
//
//   channel  | direction | payload                                   | transaction
//   item     | in        | in_byte, end_of_input                     | valid && ready
//   result   | out       | out_byte0..3, byte_count, last_of_run, status | valid && ready
//
// A token byte gives no result unless it ends the input; a literal byte gives one result.
// A fill byte gives ceil(n / lanes) results, one per cycle in the back end unless result
// stalls, where n is the repeat count (2 to 129) and lanes is OUT_LANES clamped to 1..4.
// A two-entry command queue lets the front end keep accepting while a run expands.
// Reset clears the token phase, the queue and the result valid flag.
// A stalled result holds its register and the back end waits; the queue fills, then input stalls.
module packbits_rle_decoder #(
	parameter int OUT_LANES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	pbd_in_if.sink    item,
	pbd_out_if.source result
);

	localparam int LANES = (OUT_LANES < 1) ? 1 :
		((OUT_LANES > pbd_pkg::LANE_MAX) ? pbd_pkg::LANE_MAX : OUT_LANES);

	logic          push;
	pbd_pkg::cmd_t push_cmd;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;
	pbd_pkg::cmd_t head;

	pbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	pbd_back #(
		.LANES (LANES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

`ifndef SYNTHESIS
	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("command queue overflow");

	// A result never carries more bytes than there are lanes.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.byte_count <= 3'(LANES)))
		else $error("byte_count exceeds lane count");

	// A status-only result always flags truncation and ends its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.byte_count == 3'd0) |->
		(result.data.status && result.data.last_of_run))
		else $error("malformed status-only result");

	// Truncation is reported only on the last result of an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.status) |-> result.data.last_of_run)
		else $error("status set on a result that is not last");
`endif

endmodule
